@@ design/fbd_pkg.sv @@
// ----------------------------------------------------------------------------
// fbd_pkg : shared types and constants of the mono framebuffer downscaler
// geometry, fixed-point scale factors, request and config structures
// ----------------------------------------------------------------------------
`default_nettype none

package fbd_pkg;

  // source framebuffer and output geometry
  localparam int SRC_WIDTH  = 160;
  localparam int SRC_HEIGHT = 144;
  localparam int DST_WIDTH  = 128;
  localparam int DST_HEIGHT = 64;

  // bytes in the store, four 2-bit pixels per byte
  localparam int FB_BYTES = (SRC_WIDTH * SRC_HEIGHT + 3) / 4;
  localparam int FB_AW    = $clog2(FB_BYTES);

  // linear pixel position width
  localparam int PIX_W = $clog2(SRC_WIDTH * SRC_HEIGHT);

  // source coordinate widths
  localparam int SX_W = $clog2(SRC_WIDTH);
  localparam int SY_W = $clog2(SRC_HEIGHT);

  // unsigned q8.8 scale factors, truncated
  localparam int SX_Q8 = (SRC_WIDTH * 256) / DST_WIDTH;
  localparam int SY_Q8 = (SRC_HEIGHT * 256) / DST_HEIGHT;

  // width of the scaled product before the q8.8 shift
  localparam int MAP_W = 24;

  // pixels per rendered byte
  localparam int LANES = 8;

  // input field widths
  localparam int ROW_W = 6;
  localparam int GRP_W = 4;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int PAN_W  = 9;

  // register indexes
  localparam logic [1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [1:0] REG_PAN_X      = 2'd1;
  localparam logic [1:0] REG_PAN_Y      = 2'd2;

  // request opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // default request queue depth
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic                    scale_mode;
    logic signed [PAN_W-1:0] pan_x;
    logic signed [PAN_W-1:0] pan_y;
  } fbd_cfg_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic                        is_render;
    logic [FB_AW-1:0]            fb_address;
    logic [7:0]                  fb_data;
    logic [ROW_W-1:0]            row;
    logic [GRP_W-1:0]            grp;
    logic [SY_W-1:0]             sy;
    logic [LANES-1:0][SX_W-1:0]  sx;
  } fbd_req_t;

  typedef struct packed {
    logic clearing;
  } fbd_back_stat_t;

endpackage

`default_nettype wire

@@ design/framebuffer_downscale_to_mono.sv @@
// ----------------------------------------------------------------------------
// framebuffer_downscale_to_mono : 2-bit framebuffer to 1-bit display bytes
// holds a 160x144 store of 2-bit color indices and renders 8-pixel mono
// bytes by nearest-pixel scaling or by a clamped pan offset
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  ----------------------------
//  request   in         start && !busy                 in_op, in_fb_address,
//                                                      in_fb_data, in_out_row,
//                                                      in_out_group
//  result    out        out_strobe, one cycle          out_row_echo, out_group_echo,
//                                                      out_mono_byte
//  config    in/out     psel && penable && pwrite      paddr, pwdata, prdata
//
//  - after reset the store is cleared one byte a cycle: busy stays high until
//    all 5760 store bytes are cleared; config writes are taken meanwhile
//  - a write request is popped and written to the store in the same cycle
//  - a render passes through the address, read and drain states; in the read
//    state the n distinct store bytes (1 to 3) covered by its eight source
//    pixels are fetched one at a time through the single store read port,
//    and the result strobe is registered out of the drain state
//  - busy also rises while the request queue is full
//  - results cannot be held off; each is shown for exactly one cycle
//
`default_nettype none

module framebuffer_downscale_to_mono import fbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  // request channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_op,
  input  wire logic [FB_AW-1:0]  in_fb_address,
  input  wire logic [7:0]        in_fb_data,
  input  wire logic [ROW_W-1:0]  in_out_row,
  input  wire logic [GRP_W-1:0]  in_out_group,

  // result channel
  output logic                   out_strobe,
  output logic [ROW_W-1:0]       out_row_echo,
  output logic [GRP_W-1:0]       out_group_echo,
  output logic [7:0]             out_mono_byte,

  // config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // config registers
  logic                    scale_mode_r, scale_mode_nxt;
  logic signed [PAN_W-1:0] pan_x_r, pan_x_nxt;
  logic signed [PAN_W-1:0] pan_y_r, pan_y_nxt;
  logic                    cfg_wr;
  logic [1:0]              cfg_idx;
  fbd_cfg_t                cfg;

  // front to queue, queue to back
  logic                    q_push;
  logic                    q_full;
  fbd_req_t                q_in;
  logic                    q_head_valid;
  fbd_req_t                q_head;
  logic                    q_pop;
  fbd_back_stat_t          back_stat;

  // ---------------------------------------------------------------------------
  // config port: no wait states, decode on the word index
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    scale_mode_nxt = scale_mode_r;
    pan_x_nxt      = pan_x_r;
    pan_y_nxt      = pan_y_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE_MODE: scale_mode_nxt = pwdata[0];
        REG_PAN_X:      pan_x_nxt      = $signed(pwdata[PAN_W-1:0]);
        REG_PAN_Y:      pan_y_nxt      = $signed(pwdata[PAN_W-1:0]);
        default:        ;  // unmapped word, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= 1'b1;
      pan_x_r      <= '0;
      pan_y_r      <= '0;
    end else begin
      scale_mode_r <= scale_mode_nxt;
      pan_x_r      <= pan_x_nxt;
      pan_y_r      <= pan_y_nxt;
    end
  end

  // read back, pans sign-extended
  always_comb begin
    case (cfg_idx)
      REG_SCALE_MODE: prdata = {{(CFG_DW-1){1'b0}}, scale_mode_r};
      REG_PAN_X:      prdata = {{(CFG_DW-PAN_W){pan_x_r[PAN_W-1]}}, pan_x_r};
      REG_PAN_Y:      prdata = {{(CFG_DW-PAN_W){pan_y_r[PAN_W-1]}}, pan_y_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.scale_mode = scale_mode_r;
  assign cfg.pan_x      = pan_x_r;
  assign cfg.pan_y      = pan_y_r;

  // ---------------------------------------------------------------------------
  // front: takes requests, maps the eight pixels to source coordinates
  // ---------------------------------------------------------------------------
  fbd_front u_front (
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_fb_address (in_fb_address),
    .in_fb_data    (in_fb_data),
    .in_out_row    (in_out_row),
    .in_out_group  (in_out_group),
    .cfg           (cfg),
    .back_stat     (back_stat),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in)
  );

  // ---------------------------------------------------------------------------
  // queue: lets the front keep taking requests while a render is fetching
  // ---------------------------------------------------------------------------
  fbd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop)
  );

  // ---------------------------------------------------------------------------
  // back: owns the store, clears it, applies writes, renders bytes
  // ---------------------------------------------------------------------------
  fbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_entry     (q_head),
    .pop            (q_pop),
    .stat           (back_stat),
    .out_strobe     (out_strobe),
    .out_row_echo   (out_row_echo),
    .out_group_echo (out_group_echo),
    .out_mono_byte  (out_mono_byte)
  );

endmodule

`default_nettype wire

@@ design/fbd_front.sv @@
// ----------------------------------------------------------------------------
// fbd_front : request intake and coordinate mapping
// takes requests, drops out-of-range writes, maps render pixels to source
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_front import fbd_pkg::*; (
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_op,
  input  wire logic [FB_AW-1:0] in_fb_address,
  input  wire logic [7:0]       in_fb_data,
  input  wire logic [ROW_W-1:0] in_out_row,
  input  wire logic [GRP_W-1:0] in_out_group,
  input  wire fbd_cfg_t         cfg,
  input  wire fbd_back_stat_t   back_stat,
  input  wire logic             q_full,
  output logic                  q_push,
  output fbd_req_t              q_entry
);

  logic                     accept;
  logic [6:0]               x_lane [LANES];
  logic [LANES-1:0][SX_W-1:0] sx_map;
  logic [SY_W-1:0]          sy_map;
  logic [MAP_W-1:0]         x_prod [LANES];
  logic [MAP_W-1:0]         y_prod;
  logic signed [9:0]        x_pan [LANES];
  logic signed [9:0]        y_pan;

  assign busy   = back_stat.clearing | q_full;
  assign accept = start & ~busy;

  // writes past the store are dropped here
  assign q_push = accept &
                  ((in_op == OP_RENDER) | (in_fb_address < FB_AW'(FB_BYTES)));

  // horizontal mapping, one lane per output pixel
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      x_lane[i] = {in_out_group, 3'(i)};
      x_prod[i] = MAP_W'(x_lane[i]) * MAP_W'(SX_Q8) + MAP_W'(128);
      x_pan[i]  = $signed({3'b000, x_lane[i]}) + $signed({cfg.pan_x[PAN_W-1], cfg.pan_x});
      if (cfg.scale_mode) begin
        if (x_prod[i][MAP_W-1:8] > (MAP_W-8)'(SRC_WIDTH - 1)) begin
          sx_map[i] = SX_W'(SRC_WIDTH - 1);
        end else begin
          sx_map[i] = x_prod[i][SX_W+7:8];
        end
      end else begin
        if (x_pan[i] < 0) begin
          sx_map[i] = '0;
        end else if (x_pan[i][8:0] > 9'(SRC_WIDTH - 1)) begin
          sx_map[i] = SX_W'(SRC_WIDTH - 1);
        end else begin
          sx_map[i] = x_pan[i][SX_W-1:0];
        end
      end
    end
  end

  // vertical mapping
  always_comb begin
    y_prod = MAP_W'(in_out_row) * MAP_W'(SY_Q8) + MAP_W'(128);
    y_pan  = $signed({4'b0000, in_out_row}) + $signed({cfg.pan_y[PAN_W-1], cfg.pan_y});
    if (cfg.scale_mode) begin
      if (y_prod[MAP_W-1:8] > (MAP_W-8)'(SRC_HEIGHT - 1)) begin
        sy_map = SY_W'(SRC_HEIGHT - 1);
      end else begin
        sy_map = y_prod[SY_W+7:8];
      end
    end else begin
      if (y_pan < 0) begin
        sy_map = '0;
      end else if (y_pan[8:0] > 9'(SRC_HEIGHT - 1)) begin
        sy_map = SY_W'(SRC_HEIGHT - 1);
      end else begin
        sy_map = y_pan[SY_W-1:0];
      end
    end
  end

  always_comb begin
    q_entry.is_render  = (in_op == OP_RENDER);
    q_entry.fb_address = in_fb_address;
    q_entry.fb_data    = in_fb_data;
    q_entry.row        = in_out_row;
    q_entry.grp        = in_out_group;
    q_entry.sy         = sy_map;
    q_entry.sx         = sx_map;
  end

endmodule

`default_nettype wire

@@ design/fbd_queue.sv @@
// ----------------------------------------------------------------------------
// fbd_queue : short request queue between front and back
// in-order, push and pop in the same cycle allowed
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_queue import fbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire fbd_req_t push_entry,
  output logic          full,
  output logic          head_valid,
  output fbd_req_t      head_entry,
  input  wire logic     pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fbd_req_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ design/fbd_back.sv @@
// ----------------------------------------------------------------------------
// fbd_back : framebuffer store and render engine
// clears the store after reset, applies writes, fetches render bytes
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_back import fbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire fbd_req_t   head_entry,
  output logic            pop,
  output fbd_back_stat_t  stat,
  output logic            out_strobe,
  output logic [ROW_W-1:0] out_row_echo,
  output logic [GRP_W-1:0] out_group_echo,
  output logic [7:0]      out_mono_byte
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [7:0]       mem [FB_BYTES];
  logic [7:0]       mem_rdata_r;
  logic             mem_we;
  logic [FB_AW-1:0] mem_addr;
  logic [7:0]       mem_wdata;

  logic [2:0]       state_r, state_nxt;
  logic [FB_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LANES-1:0] pending_r, pending_nxt;
  logic [LANES-1:0] rd_mask_r, rd_mask_nxt;
  logic [7:0]       mono_r, mono_nxt;

  logic [SY_W-1:0]             sy_r;
  logic [LANES-1:0][SX_W-1:0]  sx_r;
  logic [ROW_W-1:0]            row_r;
  logic [GRP_W-1:0]            grp_r;
  logic [FB_AW-1:0]            byte_r [LANES];
  logic [1:0]                  lane_r [LANES];

  logic             out_strobe_r, out_strobe_nxt;
  logic [7:0]       out_mono_r;
  logic [ROW_W-1:0] out_row_r;
  logic [GRP_W-1:0] out_grp_r;

  logic [PIX_W-1:0] row_base;
  logic [PIX_W-1:0] pix_pos [LANES];
  logic [2:0]       pick;
  logic [LANES-1:0] match;
  logic [7:0]       merged;

  function automatic logic lane_odd(logic [7:0] b, logic [1:0] lane);
    logic bit_val;
    case (lane)
      2'd0:    bit_val = b[0];
      2'd1:    bit_val = b[2];
      2'd2:    bit_val = b[4];
      2'd3:    bit_val = b[6];
      default: bit_val = 1'b0;
    endcase
    return bit_val;
  endfunction

  // linear positions, one multiplier for the row base
  always_comb begin
    row_base = PIX_W'(sy_r) * PIX_W'(SRC_WIDTH);
    for (int i = 0; i < LANES; i++) begin
      pix_pos[i] = row_base + PIX_W'(sx_r[i]);
    end
  end

  // first pixel still waiting for its byte
  always_comb begin
    pick = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        pick = 3'(i);
      end
    end
    for (int i = 0; i < LANES; i++) begin
      match[i] = pending_r[i] & (byte_r[i] == byte_r[pick]);
    end
  end

  // fold the byte that came back into the output bits
  always_comb begin
    merged = mono_r;
    for (int i = 0; i < LANES; i++) begin
      if (rd_mask_r[i] && lane_odd(mem_rdata_r, lane_r[i])) begin
        merged[LANES-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    pending_nxt    = pending_r;
    rd_mask_nxt    = '0;
    mono_nxt       = merged;
    out_strobe_nxt = 1'b0;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = byte_r[pick];
    mem_wdata      = head_entry.fb_data;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == FB_AW'(FB_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = head_entry.fb_address;
        if (head_valid) begin
          pop = 1'b1;
          if (head_entry.is_render) begin
            state_nxt = ST_ADDR;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_ADDR: begin
        pending_nxt = '1;
        mono_nxt    = '0;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        rd_mask_nxt = match;
        pending_nxt = pending_r & ~match;
        if ((pending_r & ~match) == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      pending_r    <= '0;
      rd_mask_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pending_r    <= pending_nxt;
      rd_mask_r    <= rd_mask_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mono_r <= mono_nxt;
    if (state_r == ST_IDLE && head_valid && head_entry.is_render) begin
      sy_r  <= head_entry.sy;
      sx_r  <= head_entry.sx;
      row_r <= head_entry.row;
      grp_r <= head_entry.grp;
    end
    if (state_r == ST_ADDR) begin
      for (int i = 0; i < LANES; i++) begin
        byte_r[i] <= pix_pos[i][PIX_W-1:2];
        lane_r[i] <= pix_pos[i][1:0];
      end
    end
    if (state_r == ST_DRAIN) begin
      out_mono_r <= merged;
      out_row_r  <= row_r;
      out_grp_r  <= grp_r;
    end
  end

  // single-port store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  assign stat.clearing  = (state_r == ST_CLEAR);
  assign out_strobe     = out_strobe_r;
  assign out_mono_byte  = out_mono_r;
  assign out_row_echo   = out_row_r;
  assign out_group_echo = out_grp_r;

endmodule

`default_nettype wire

@@ design/fbd_checker.sv @@
// ----------------------------------------------------------------------------
// fbd_checker : port-level checks for the mono downscaler
// watches reset behavior, result strobe spacing and config read-back
// ----------------------------------------------------------------------------
`default_nettype none

module fbd_checker import fbd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              busy,
  input wire logic              out_strobe,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [CFG_AW-1:0] paddr,
  input wire logic [CFG_DW-1:0] pwdata,
  input wire logic [CFG_DW-1:0] prdata
);

  // store clearing starts right out of reset
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low after reset");

  // no result comes out of reset
  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // each render passes through its address, read and drain states, so strobes never abut
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // a scale_mode write reads back on the next cycle
  a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(psel && penable && pwrite && paddr[3:2] == REG_SCALE_MODE)
     && paddr[3:2] == REG_SCALE_MODE) |-> (prdata[0] == $past(pwdata[0])))
    else $error("scale_mode read-back mismatch");

endmodule

bind framebuffer_downscale_to_mono fbd_checker u_fbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);

`default_nettype wire

@@ verif/tb_framebuffer_downscale_to_mono.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framebuffer_downscale_to_mono : self-checking bench of the mono downscaler
// a short table of directed requests, then phases of random traffic under
// several scale and pan settings; every rendered byte is checked against a
// local model of the store and of the coordinate mapping
// ----------------------------------------------------------------------------
module tb_framebuffer_downscale_to_mono;
  import fbd_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 138;
  // a render holds the back end through its store reads, and the queue holds two
  // more requests behind it
  localparam int SETTLE_CYCLES   = 32;
  // the clearing pass after reset is the longest quiet stretch of a good run
  localparam int WATCHDOG_LIMIT  = 8 * FB_BYTES;

  typedef enum bit {STEP_REQUEST, STEP_CONFIG} step_kind_t;

  // one row of the directed table; for a config row addr is the register
  // index and data the value written
  typedef struct packed {
    step_kind_t kind;
    logic       op;
    int         addr;
    int         data;
    int         row;
    int         grp;
    bit         typed;
    logic [7:0] mono;
  } step_t;

  typedef struct {
    int         row;
    int         grp;
    logic [7:0] mono;
  } mono_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_op = OP_WRITE;
  logic [FB_AW-1:0]     in_fb_address = '0;
  logic [7:0]           in_fb_data = '0;
  logic [ROW_W-1:0]     in_out_row = '0;
  logic [GRP_W-1:0]     in_out_group = '0;
  logic                 out_strobe;
  logic [ROW_W-1:0]     out_row_echo;
  logic [GRP_W-1:0]     out_group_echo;
  logic [7:0]           out_mono_byte;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  // local copy of the framebuffer and of the registers
  logic [7:0]           frame_copy [FB_BYTES];
  bit                   cfg_scale = 1'b1;
  int                   cfg_pan_x = 0;
  int                   cfg_pan_y = 0;

  // rendered bytes still owed by the block, oldest first
  mono_byte_t           owed_bytes [$];
  mono_byte_t           want;

  int errors          = 0;
  int items_sent      = 0;
  int renders_checked = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;
  int burst_left      = 1;
  int phase_end;
  int pick_x;
  int pick_y;

  // directed table: reset contents, store edges, ignored writes past the
  // store, odd and even color indices, both modes and both pan extremes
  step_t plan [24] = '{
    // store is cleared by reset, so any render is blank
    '{STEP_REQUEST, OP_RENDER, 0,    0,     0,  0,  1'b1, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     63, 15, 1'b1, 8'h00},
    // first and last store bytes, then two writes past the store
    '{STEP_REQUEST, OP_WRITE,  0,    8'hff, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_WRITE,  5759, 8'hff, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_WRITE,  8191, 8'haa, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_WRITE,  5760, 8'h55, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     63, 15, 1'b0, 8'h00},
    // color indices 0, 3, 1, 2 from left to right
    '{STEP_REQUEST, OP_WRITE,  1,    8'h9c, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     0,  0,  1'b0, 8'h00},
    // pan mode with no offset
    '{STEP_CONFIG,  OP_WRITE,  REG_SCALE_MODE, 0, 0, 0, 1'b0, 8'h00},
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_X,      0, 0, 0, 1'b0, 8'h00},
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_Y,      0, 0, 0, 1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     0,  0,  1'b0, 8'h00},
    // most negative pan clamps every pixel to the top left corner
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_X,   -256, 0, 0, 1'b0, 8'h00},
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_Y,   -256, 0, 0, 1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     63, 15, 1'b1, 8'hff},
    // most positive pan clamps every pixel to the bottom right corner
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_X,    255, 0, 0, 1'b0, 8'h00},
    '{STEP_CONFIG,  OP_WRITE,  REG_PAN_Y,    255, 0, 0, 1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     0,  0,  1'b1, 8'hff},
    '{STEP_REQUEST, OP_WRITE,  5759, 8'h3f, 0,  0,  1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     63, 15, 1'b1, 8'h00},
    // back to scaling, a render in the middle of the display
    '{STEP_CONFIG,  OP_WRITE,  REG_SCALE_MODE, 1, 0, 0, 1'b0, 8'h00},
    '{STEP_REQUEST, OP_RENDER, 0,    0,     31, 7,  1'b0, 8'h00}
  };

  framebuffer_downscale_to_mono dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_fb_address  (in_fb_address),
    .in_fb_data     (in_fb_data),
    .in_out_row     (in_out_row),
    .in_out_group   (in_out_group),
    .out_strobe     (out_strobe),
    .out_row_echo   (out_row_echo),
    .out_group_echo (out_group_echo),
    .out_mono_byte  (out_mono_byte),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  // source coordinate of one display coordinate: nearest pixel in q8.8 when
  // scaling, offset with a floor of zero when panning, then the edge clamp
  function automatic int src_coord(int d, int scale_q8, int pan, int limit);
    int s;
    if (cfg_scale) begin
      s = (d * scale_q8 + 128) >>> 8;
    end else begin
      s = d + pan;
      if (s < 0) s = 0;
    end
    if (s >= limit) s = limit - 1;
    return s;
  endfunction

  // byte address holding source pixel (sx, sy)
  function automatic int byte_of(int sx, int sy);
    return (sx + sy * SRC_WIDTH) >> 2;
  endfunction

  // eight mono pixels of one display row and column group, leftmost in bit 7
  function automatic logic [7:0] render_byte(int row, int grp);
    int sy;
    int p;
    logic [7:0] mono;
    mono = '0;
    sy = src_coord(row, SY_Q8, cfg_pan_y, SRC_HEIGHT);
    for (int i = 0; i < LANES; i++) begin
      p = src_coord(grp * LANES + i, SX_Q8, cfg_pan_x, SRC_WIDTH) + sy * SRC_WIDTH;
      // odd color index lights the pixel
      mono[7 - i] = frame_copy[p >> 2][2 * (p % 4)];
    end
    return mono;
  endfunction

  // present one request and hold it until taken; the local model follows
  // the block in the order requests are taken
  task automatic issue(input logic op, input int addr, input int data, input int row,
                       input int grp, input bit typed, input logic [7:0] mono);
    mono_byte_t r;
    in_op         <= op;
    in_fb_address <= addr[FB_AW-1:0];
    in_fb_data    <= data[7:0];
    in_out_row    <= row[ROW_W-1:0];
    in_out_group  <= grp[GRP_W-1:0];
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      // writes past the store are dropped by the block
      if (addr < FB_BYTES) frame_copy[addr] = data[7:0];
    end else begin
      r.row  = row;
      r.grp  = grp;
      r.mono = typed ? mono : render_byte(row, grp);
      owed_bytes.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic hold_start(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // stop sending, let every owed byte arrive, then let trailing writes retire
  task automatic drain_results();
    start <= 1'b0;
    while (owed_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write with a setup and an access phase, then a quiet gap; only called with the block idle
  task automatic set_register(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= CFG_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SCALE_MODE: cfg_scale = val[0];
      REG_PAN_X:      cfg_pan_x = int'($signed(val[PAN_W-1:0]));
      REG_PAN_Y:      cfg_pan_y = int'($signed(val[PAN_W-1:0]));
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // sender pacing: bursts of random length, then a short gap, a long gap,
  // no gap at all, or now and then a full drain of the result side
  task automatic pace();
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 9))
        0:       drain_results();
        1:       hold_start($urandom_range(9, 40));
        2, 3:    ;
        default: hold_start($urandom_range(1, 6));
      endcase
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic send(input logic op, input int addr, input int data, input int row,
                      input int grp);
    issue(op, addr, data, row, grp, 1'b0, 8'h00);
    pace();
  endtask

  // fill the store bytes that one render will read (skipping some), then
  // render it, so most renders see fresh random pixels
  task automatic fill_and_render();
    int row;
    int grp;
    int sy;
    int lo;
    int hi;
    row = $urandom_range(0, 63);
    grp = $urandom_range(0, 15);
    sy  = src_coord(row, SY_Q8, cfg_pan_y, SRC_HEIGHT);
    lo  = byte_of(src_coord(grp * LANES, SX_Q8, cfg_pan_x, SRC_WIDTH), sy);
    hi  = byte_of(src_coord(grp * LANES + LANES - 1, SX_Q8, cfg_pan_x, SRC_WIDTH), sy);
    for (int b = lo; b <= hi; b++) begin
      if ($urandom_range(0, 5) != 0)
        send(OP_WRITE, b, $urandom_range(0, 255), $urandom_range(0, 63),
             $urandom_range(0, 15));
    end
    send(OP_RENDER, $urandom_range(0, 8191), $urandom_range(0, 255), row, grp);
  endtask

  // one field of a rendered byte against the oldest owed byte
  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  // result side and watchdog, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (owed_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got row %0d group %0d byte %02h",
                 $time, out_row_echo, out_group_echo, out_mono_byte);
      end else begin
        want = owed_bytes.pop_front();
        check_field("row_echo", want.row, int'(out_row_echo));
        check_field("group_echo", want.grp, int'(out_group_echo));
        check_field("mono_byte", int'(want.mono), int'(out_mono_byte));
        renders_checked++;
      end
    end
    // any request, result or register write counts as progress
    if ((start && !busy) || out_strobe || (psel && penable && pwrite))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results owed", $time, quiet_cycles,
               owed_bytes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    foreach (frame_copy[a]) frame_copy[a] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table; the block is still clearing its store at first
    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CONFIG) begin
        drain_results();
        set_register(plan[k].addr[1:0], plan[k].data);
      end else begin
        issue(plan[k].op, plan[k].addr, plan[k].data, plan[k].row, plan[k].grp,
              plan[k].typed, plan[k].mono);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          set_register(REG_SCALE_MODE, 1);
          pick_x = int'($urandom_range(0, 511)) - 256;
          pick_y = int'($urandom_range(0, 511)) - 256;
        end
        1: begin
          set_register(REG_SCALE_MODE, 0);
          pick_x = 0;
          pick_y = 0;
        end
        2: begin
          set_register(REG_SCALE_MODE, 0);
          pick_x = -256;
          pick_y = 255;
        end
        3: begin
          set_register(REG_SCALE_MODE, 0);
          pick_x = 255;
          pick_y = -256;
        end
        default: begin
          set_register(REG_SCALE_MODE, $urandom_range(0, 1));
          // mostly small offsets so pan renders stay off the clamped edges
          if ($urandom_range(0, 2) != 0) begin
            pick_x = int'($urandom_range(0, 96)) - 48;
            pick_y = int'($urandom_range(0, 96)) - 48;
          end else begin
            pick_x = int'($urandom_range(0, 511)) - 256;
            pick_y = int'($urandom_range(0, 511)) - 256;
          end
        end
      endcase
      set_register(REG_PAN_X, pick_x);
      set_register(REG_PAN_Y, pick_y);
      settings_used++;

      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          fill_and_render();
        end else if ($urandom_range(0, 1) == 0) begin
          // stray write anywhere, past the store too
          send(OP_WRITE, $urandom_range(0, 8191), $urandom_range(0, 255),
               $urandom_range(0, 63), $urandom_range(0, 15));
        end else begin
          send(OP_RENDER, $urandom_range(0, 8191), $urandom_range(0, 255),
               $urandom_range(0, 63), $urandom_range(0, 15));
        end
      end
    end

    drain_results();
    errors += owed_bytes.size();

    $display("covered %0d directed steps and %0d random requests, %0d rendered bytes checked,",
             $size(plan), items_sent, renders_checked);
    $display("across %0d random register settings in scale and pan modes", settings_used);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/fbd_pkg.sv
design/fbd_front.sv
design/fbd_queue.sv
design/fbd_back.sv
design/framebuffer_downscale_to_mono.sv
design/fbd_checker.sv
verif/tb_framebuffer_downscale_to_mono.sv
